// ----- rtl/escape_sequence_decoder_top_assert.svh -----
// assertion macros used by the checker file
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ESD_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("escape decoder port assertion failed");

// concurrent assertion on the block clock and reset
`define ESD_ASSERT(lbl, prop) `ESD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/esd_pkg.sv -----
`default_nettype none

package esd_pkg;

  localparam int unsigned CharW      = 32;
  localparam int unsigned PosW       = 32;
  localparam int unsigned ValW       = 64;
  localparam int unsigned MaxResults = 3;

  localparam logic [CharW-1:0] MaxCharReset = 32'd65535;

  localparam logic [CharW-1:0] ChBackslash = 32'h5C;
  localparam logic [CharW-1:0] ChX         = 32'h78;
  localparam logic [CharW-1:0] ChZero      = 32'h30;
  localparam logic [CharW-1:0] ChSeven     = 32'h37;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_ESCAPE = 2'd1,
    ERR_BAD_VALUE  = 2'd2
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [CharW-1:0]  ch;
    err_e              code;
    logic [PosW-1:0]   pos;
    logic [ValW-1:0]   val;
    logic              last;
  } result_t;

  // results caused by one input beat, sent out one per cycle while the output is not stalled
  typedef struct packed {
    logic                         valid;
    logic [1:0]                   cnt;
    result_t [MaxResults-1:0]     res;
  } bundle_t;

  function automatic result_t mk_char(input logic [CharW-1:0] ch);
    result_t r;
    r      = '0;
    r.kind = KIND_CHAR;
    r.code = ERR_NONE;
    r.ch   = ch;
    return r;
  endfunction

  function automatic result_t mk_err(input err_e code, input logic [PosW-1:0] pos,
                                     input logic [ValW-1:0] val);
    result_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.code = code;
    r.pos  = pos;
    r.val  = val;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_end();
    result_t r;
    r      = '0;
    r.kind = KIND_END;
    r.code = ERR_NONE;
    r.last = 1'b1;
    return r;
  endfunction

  // {hit, mapped character} for the single-letter escapes
  function automatic logic [CharW:0] simple_escape(input logic [CharW-1:0] c);
    logic [CharW:0] r;
    r = '0;
    case (c)
      32'h62: r = {1'b1, 32'd8};   // b
      32'h66: r = {1'b1, 32'd12};  // f
      32'h6E: r = {1'b1, 32'd10};  // n
      32'h72: r = {1'b1, 32'd13};  // r
      32'h74: r = {1'b1, 32'd9};   // t
      32'h76: r = {1'b1, 32'd11};  // v
      32'h61: r = {1'b1, 32'd7};   // a
      32'h5C, 32'h22, 32'h27: r = {1'b1, c};
      default: r = '0;
    endcase
    return r;
  endfunction

  // {hit, digit value} for 0-9 a-f A-F
  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[32'h30:32'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[32'h61:32'h66], [32'h41:32'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/esd_core.sv -----
`default_nettype none

module esd_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [esd_pkg::CharW-1:0] in_char_i,
  input  wire logic                    last_in_string_i,
  input  wire logic                    cfg_valid_i,
  input  wire logic [esd_pkg::CharW-1:0] cfg_data_i,
  input  wire logic                    bnd_free_i,
  output esd_pkg::bundle_t             bundle_o
);
  import esd_pkg::*;

  typedef enum logic [2:0] {
    MODE_PLAIN     = 3'd0,
    MODE_ESC       = 3'd1,
    MODE_HEX_FIRST = 3'd2,
    MODE_HEX       = 3'd3,
    MODE_OCT       = 3'd4
  } mode_e;

  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic             accept, advance;

  logic [CharW-1:0] max_q;
  mode_e            mode_q, mode_d;
  logic [ValW-1:0]  acc_q, acc_d;
  logic [1:0]       oct_q, oct_d;
  logic [PosW-1:0]  cidx_q, cidx_d;
  logic [PosW-1:0]  eidx_q, eidx_d;
  logic             ovf_q, ovf_d;
  logic             drop_q, drop_d;

  assign in_stall_o = in_vld_q && !bnd_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = in_vld_q && bnd_free_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    result_t [MaxResults-1:0] res;
    logic [1:0]               n;
    logic                     err;
    logic                     redo;
    logic [CharW:0]           esc;
    logic [4:0]               hd;

    mode_d = mode_q;
    acc_d  = acc_q;
    oct_d  = oct_q;
    cidx_d = cidx_q;
    eidx_d = eidx_q;
    ovf_d  = ovf_q;
    drop_d = drop_q;
    res    = '0;
    n      = '0;
    err    = 1'b0;
    redo   = 1'b0;
    esc    = simple_escape(in_char_q);
    hd     = hex_digit(in_char_q);

    if (drop_q) begin
      if (in_last_q) begin
        drop_d = 1'b0;
        mode_d = MODE_PLAIN;
        acc_d  = '0;
        oct_d  = '0;
        cidx_d = '0;
        eidx_d = '0;
        ovf_d  = 1'b0;
      end
    end else begin
      case (mode_q)
        MODE_PLAIN: begin
          redo = 1'b1;
        end
        MODE_ESC: begin
          if (esc[CharW]) begin
            res[n] = mk_char(esc[CharW-1:0]);
            n      = n + 2'd1;
            mode_d = MODE_PLAIN;
          end else if (in_char_q == ChX) begin
            mode_d = MODE_HEX_FIRST;
            acc_d  = '0;
            ovf_d  = 1'b0;
          end else if (in_char_q inside {[ChZero:ChSeven]}) begin
            mode_d = MODE_OCT;
            acc_d  = {61'd0, in_char_q[2:0]};
            oct_d  = 2'd1;
          end else begin
            res[n] = mk_err(ERR_BAD_ESCAPE, eidx_q, '0);
            n      = n + 2'd1;
            err    = 1'b1;
          end
        end
        MODE_HEX_FIRST, MODE_HEX: begin
          if (hd[4]) begin
            if (ovf_q || (acc_q[ValW-1:ValW-4] != 4'd0)) begin
              ovf_d = 1'b1;
              acc_d = '1;
            end else begin
              acc_d = {acc_q[ValW-5:0], hd[3:0]};
            end
            mode_d = MODE_HEX;
          end else if (mode_q == MODE_HEX_FIRST) begin
            res[n] = mk_err(ERR_BAD_VALUE, eidx_q, '0);
            n      = n + 2'd1;
            err    = 1'b1;
          end else if (ovf_q || (acc_q > {32'd0, max_q})) begin
            res[n] = mk_err(ERR_BAD_VALUE, eidx_q, acc_q);
            n      = n + 2'd1;
            err    = 1'b1;
          end else begin
            res[n] = mk_char(acc_q[CharW-1:0]);
            n      = n + 2'd1;
            mode_d = MODE_PLAIN;
            redo   = 1'b1;
          end
        end
        MODE_OCT: begin
          if (in_char_q inside {[ChZero:ChSeven]}) begin
            acc_d = {acc_q[ValW-4:0], in_char_q[2:0]};
            oct_d = oct_q + 2'd1;
            if (oct_q == 2'd2) begin
              // third digit closes the number at once
              res[n] = mk_char(acc_d[CharW-1:0]);
              n      = n + 2'd1;
              mode_d = MODE_PLAIN;
              oct_d  = '0;
            end
          end else begin
            res[n] = mk_char(acc_q[CharW-1:0]);
            n      = n + 2'd1;
            mode_d = MODE_PLAIN;
            oct_d  = '0;
            redo   = 1'b1;
          end
        end
        default: begin
          redo = 1'b1;
        end
      endcase

      // plain-text handling, also for the character that closed a number
      if (redo) begin
        if (in_char_q == ChBackslash) begin
          mode_d = MODE_ESC;
          eidx_d = (cidx_q == '1) ? cidx_q : cidx_q + 32'd1;
        end else begin
          res[n] = mk_char(in_char_q);
          n      = n + 2'd1;
        end
      end

      if (!err && in_last_q) begin
        case (mode_d)
          MODE_PLAIN: begin
            res[n] = mk_end();
            n      = n + 2'd1;
          end
          MODE_ESC, MODE_HEX_FIRST: begin
            res[n] = mk_err(ERR_BAD_ESCAPE, eidx_d, '0);
            n      = n + 2'd1;
            err    = 1'b1;
          end
          MODE_HEX: begin
            if (ovf_d || (acc_d > {32'd0, max_q})) begin
              res[n] = mk_err(ERR_BAD_VALUE, eidx_d, acc_d);
              n      = n + 2'd1;
              err    = 1'b1;
            end else begin
              res[n] = mk_char(acc_d[CharW-1:0]);
              n      = n + 2'd1;
              res[n] = mk_end();
              n      = n + 2'd1;
            end
          end
          default: begin
            res[n] = mk_char(acc_d[CharW-1:0]);
            n      = n + 2'd1;
            res[n] = mk_end();
            n      = n + 2'd1;
          end
        endcase
      end

      if (in_last_q || err) begin
        drop_d = !in_last_q;
        mode_d = MODE_PLAIN;
        acc_d  = '0;
        oct_d  = '0;
        cidx_d = '0;
        eidx_d = '0;
        ovf_d  = 1'b0;
      end else if (cidx_q != '1) begin
        cidx_d = cidx_q + 32'd1;
      end
    end

    bundle_o.valid = advance && (n != 2'd0);
    bundle_o.cnt   = n;
    bundle_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      max_q    <= MaxCharReset;
      mode_q   <= MODE_PLAIN;
      acc_q    <= '0;
      oct_q    <= '0;
      cidx_q   <= '0;
      eidx_q   <= '0;
      ovf_q    <= 1'b0;
      drop_q   <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (advance) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        oct_q  <= oct_d;
        cidx_q <= cidx_d;
        eidx_q <= eidx_d;
        ovf_q  <= ovf_d;
        drop_q <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_char_q <= in_char_i;
      in_last_q <= last_in_string_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/esd_outbuf.sv -----
`default_nettype none

module esd_outbuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  esd_pkg::bundle_t      bundle_i,
  output logic                  bnd_free_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output esd_pkg::result_t      result_o
);
  import esd_pkg::*;

  logic                     vld_q;
  logic [1:0]               idx_q;
  logic [1:0]               cnt_q;
  result_t [MaxResults-1:0] res_q;
  logic                     fire, done;

  assign fire        = vld_q && !out_stall_i;
  assign done        = fire && (idx_q == cnt_q - 2'd1);
  assign bnd_free_o  = !vld_q || done;
  assign out_valid_o = vld_q;
  assign result_o    = res_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (bundle_i.valid) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (done) begin
      vld_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bundle_i.valid) begin
      cnt_q <= bundle_i.cnt;
      res_q <= bundle_i.res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/escape_sequence_decoder_top.sv -----
`default_nettype none

// C-style escape decoder for wide-character strings. One character enters per
// in beat; plain characters, simple escapes, \x hex numbers (checked against
// the max-char register) and octal numbers of up to three digits are decoded,
// and each string is closed by an end result or by one error result, after
// which the rest of that string is dropped. Input beats are taken one per
// cycle as long as each causes at most one result and the output is not
// stalled; a character that causes n results (n is at most 3, e.g. a number
// closed by a plain character at the end of a string) holds the input until
// the result register has sent them all, one beat per cycle unless stalled.
// The configuration register is always ready.
module escape_sequence_decoder_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [esd_pkg::CharW-1:0] in_char_i,
  input  wire logic                      last_in_string_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [esd_pkg::CharW-1:0] cfg_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [1:0]                     result_kind_o,
  output logic [esd_pkg::CharW-1:0]      out_char_o,
  output logic [1:0]                     error_code_o,
  output logic [esd_pkg::PosW-1:0]       error_position_o,
  output logic [esd_pkg::ValW-1:0]       error_value_o,
  output logic                           last_of_run_o
);
  import esd_pkg::*;

  bundle_t bundle;
  logic    bnd_free;
  result_t result;

  assign cfg_ready_o = 1'b1;

  esd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_char_i        (in_char_i),
    .last_in_string_i (last_in_string_i),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .bnd_free_i       (bnd_free),
    .bundle_o         (bundle)
  );

  esd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bundle_i    (bundle),
    .bnd_free_o  (bnd_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign result_kind_o    = result.kind;
  assign out_char_o       = result.ch;
  assign error_code_o     = result.code;
  assign error_position_o = result.pos;
  assign error_value_o    = result.val;
  assign last_of_run_o    = result.last;

endmodule

`default_nettype wire

// ----- rtl/esd_checker.sv -----
`default_nettype none

`include "escape_sequence_decoder_top_assert.svh"

module esd_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  input  wire logic [1:0]                result_kind_o,
  input  wire logic [esd_pkg::CharW-1:0] out_char_o,
  input  wire logic [1:0]                error_code_o,
  input  wire logic [esd_pkg::PosW-1:0]  error_position_o,
  input  wire logic [esd_pkg::ValW-1:0]  error_value_o,
  input  wire logic                      last_of_run_o
);
  import esd_pkg::*;

  logic [2+CharW+2+PosW+ValW:0] out_beat;
  logic                         char_beat, err_beat, end_beat;
  logic                         clean_beat, known_code;

  assign out_beat   = {result_kind_o, out_char_o, error_code_o, error_position_o,
                       error_value_o, last_of_run_o};
  assign char_beat  = out_valid_o && result_kind_o == KIND_CHAR;
  assign err_beat   = out_valid_o && result_kind_o == KIND_ERROR;
  assign end_beat   = out_valid_o && result_kind_o == KIND_END;
  assign clean_beat = error_code_o == ERR_NONE && error_value_o == '0;
  assign known_code = error_code_o == ERR_BAD_ESCAPE || error_code_o == ERR_BAD_VALUE;

  // a stalled result beat holds
  `ESD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat))

  // decoded characters never close a run and carry no error
  `ESD_ASSERT(a_char_clean, char_beat |-> !last_of_run_o && clean_beat)

  // an error result closes the run with a real code
  `ESD_ASSERT(a_err_closes, err_beat |-> last_of_run_o && out_char_o == '0 && known_code)

  // end results are empty and close the run
  `ESD_ASSERT(a_end_empty, end_beat |-> last_of_run_o && clean_beat && error_position_o == '0)

  // only bad-value errors report a value
  `ESD_ASSERT(a_value_only_bad, out_valid_o && error_code_o != ERR_BAD_VALUE |-> error_value_o == '0)

endmodule

bind escape_sequence_decoder_top esd_checker u_esd_checker (.*);

`default_nettype wire
